@@ rtl/core/xu_pkg.sv @@
package xu_pkg;

    typedef enum logic [4:0] {
        ACT_ADDS_REG = 5'd0,
        ACT_ADDS_IMM = 5'd1,
        ACT_SUBS_REG = 5'd2,
        ACT_SUBS_IMM = 5'd3,
        ACT_CMP_IMM  = 5'd4,
        ACT_ANDS     = 5'd5,
        ACT_EOR      = 5'd6,
        ACT_ORR      = 5'd7,
        ACT_ADD_REG  = 5'd8,
        ACT_ADD_IMM  = 5'd9,
        ACT_MUL      = 5'd10,
        ACT_MOVZ     = 5'd11,
        ACT_SHIFT    = 5'd12,
        ACT_B        = 5'd13,
        ACT_BR       = 5'd14,
        ACT_BCOND    = 5'd15,
        ACT_CBZ      = 5'd16,
        ACT_CBNZ     = 5'd17,
        ACT_LDUR     = 5'd18,
        ACT_LDURH    = 5'd19,
        ACT_LDURB    = 5'd20,
        ACT_STUR     = 5'd21,
        ACT_STURH    = 5'd22,
        ACT_STURB    = 5'd23,
        ACT_HLT      = 5'd24
    } t_action;

    localparam logic [3:0] COND_EQ = 4'b0000;
    localparam logic [3:0] COND_NE = 4'b0001;
    localparam logic [3:0] COND_GE = 4'b1010;
    localparam logic [3:0] COND_LT = 4'b1011;
    localparam logic [3:0] COND_GT = 4'b1100;
    localparam logic [3:0] COND_LE = 4'b1101;

    localparam logic [4:0] ZERO_REG = 5'd31;

    typedef enum logic [1:0] {
        MSZ_B = 2'd0,
        MSZ_H = 2'd1,
        MSZ_D = 2'd2
    } t_msize;

    typedef struct packed {
        logic   re;
        logic   we;
        t_msize size;
    } t_mem_op;

    typedef struct packed {
        logic [4:0]  action;
        logic [4:0]  dest_reg;
        logic [4:0]  data_reg;
        logic [3:0]  cond_code;
        logic [11:0] imm12;
        logic [15:0] imm16;
        logic [25:0] off26;
        logic [18:0] off19;
        logic [8:0]  off9;
    } t_instr;

    typedef struct packed {
        logic        wr;
        logic [4:0]  wreg;
        logic [63:0] wval;
        logic        is_mul;
        logic        is_load;
        t_msize      msize;
        logic        fn;
        logic        fz;
        logic [63:0] next_pc;
        logic        halt;
    } t_exec;

    function automatic logic [3:0] msize_bytes(t_msize s);
        case (s)
            MSZ_B:   return 4'd1;
            MSZ_H:   return 4'd2;
            default: return 4'd8;
        endcase
    endfunction

endpackage

@@ rtl/core/xu_if.sv @@
interface xu_instr_if;
    logic               valid;
    logic               ready;
    logic [4:0]         action;
    logic [4:0]         dest_reg;
    logic [4:0]         src_reg_a;
    logic [4:0]         src_reg_b;
    logic [4:0]         data_reg;
    logic [3:0]         cond_code;
    logic [11:0]        imm12;
    logic [15:0]        imm16;
    logic signed [25:0] branch_offset26;
    logic signed [18:0] branch_offset19;
    logic signed [8:0]  mem_offset9;

    modport source(output valid, action, dest_reg, src_reg_a, src_reg_b, data_reg, cond_code,
                   imm12, imm16, branch_offset26, branch_offset19, mem_offset9,
                   input ready);
    modport sink(input valid, action, dest_reg, src_reg_a, src_reg_b, data_reg, cond_code,
                 imm12, imm16, branch_offset26, branch_offset19, mem_offset9,
                 output ready);
endinterface

interface xu_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] next_pc;
    logic        reg_write;
    logic [4:0]  written_reg;
    logic [63:0] written_value;
    logic        flag_neg;
    logic        flag_zero;
    logic        halted;

    modport source(output valid, next_pc, reg_write, written_reg, written_value, flag_neg,
                   flag_zero, halted, input ready);
    modport sink(input valid, next_pc, reg_write, written_reg, written_value, flag_neg,
                 flag_zero, halted, output ready);
endinterface

@@ rtl/core/armv8_subset_execute_unit.sv @@
// Executes one decoded ARMv8 integer instruction per item against a 32 x 64-bit register
// file, PC, N/Z flags, halt bit and a little-endian byte data memory of DMEM_BYTES bytes
// (a power of two; addresses wrap). Stages: register-file read, execute (adder, shifter,
// three 32x32 partial products, memory access), then write-back. A new item is taken no
// sooner than the last leaves write-back (which waits for a free result register), and
// its register read picks up that write-back value through a bypass. The result is held
// until taken. Registers read as zero after reset; data memory needs no clearing pass.
module armv8_subset_execute_unit
    import xu_pkg::*;
#(
    parameter int DMEM_BYTES = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    xu_instr_if.sink      i_instr,
    xu_result_if.source   o_result
);
    localparam int AW = $clog2(DMEM_BYTES);

    logic        accept, c_done;
    logic        r_b_valid, r_c_valid, r_out_valid;
    t_instr      r_b;
    t_exec       ex, r_c;
    logic [63:0] r_pc;
    logic        r_n, r_z, r_halt;
    logic [63:0] a, b, t;
    logic [63:0] addr, off26, off19, off9, fv, cval, ld, mem_q;
    logic        set_f, take;
    t_mem_op     mop;
    logic [63:0] r_p_ll;
    logic [31:0] r_p_lh, r_p_hl;

    assign i_instr.ready = !r_b_valid && (!r_c_valid || c_done);
    assign accept        = i_instr.valid && i_instr.ready;
    assign c_done        = r_c_valid && (!r_out_valid || o_result.ready);

    xu_regfile u_rf (
        .i_clk,
        .i_rst_n,
        .i_re(accept),
        .i_raddr_a(i_instr.src_reg_a),
        .i_raddr_b(i_instr.src_reg_b),
        .i_raddr_t(i_instr.data_reg),
        .i_we(c_done && r_c.wr),
        .i_waddr(r_c.wreg),
        .i_wdata(cval),
        .o_a(a),
        .o_b(b),
        .o_t(t)
    );

    xu_dmem #(.DMEM_BYTES(DMEM_BYTES)) u_dmem (
        .i_clk,
        .i_op(mop),
        .i_addr(addr[AW-1:0]),
        .i_wdata(t),
        .o_rdata(mem_q)
    );

    assign off26 = {{36{r_b.off26[25]}}, r_b.off26, 2'b00};
    assign off19 = {{43{r_b.off19[18]}}, r_b.off19, 2'b00};
    assign off9  = {{55{r_b.off9[8]}}, r_b.off9};
    assign addr  = a + off9;

    // execute stage
    always_comb begin
        ex         = '0;
        ex.next_pc = r_pc + 64'd4;
        ex.fn      = r_n;
        ex.fz      = r_z;
        ex.halt    = r_halt;
        ex.msize   = MSZ_D;
        ex.wreg    = r_b.dest_reg;
        mop        = '0;
        mop.re     = r_b_valid;
        mop.size   = MSZ_D;
        set_f      = 1'b0;
        fv         = '0;
        take       = 1'b0;
        if (r_halt) begin
            ex.next_pc = r_pc;
        end else begin
            case (t_action'(r_b.action))
                ACT_ADDS_REG: begin
                    ex.wr = 1'b1; ex.wval = a + b; set_f = 1'b1;
                end
                ACT_ADDS_IMM: begin
                    ex.wr = 1'b1; ex.wval = a + 64'(r_b.imm12); set_f = 1'b1;
                end
                ACT_SUBS_REG: begin
                    ex.wr = 1'b1; ex.wval = a - b; set_f = 1'b1;
                end
                ACT_SUBS_IMM: begin
                    ex.wr = 1'b1; ex.wval = a - 64'(r_b.imm12); set_f = 1'b1;
                end
                ACT_CMP_IMM: begin
                    ex.wval = a - 64'(r_b.imm12); set_f = 1'b1;
                end
                ACT_ANDS: begin
                    ex.wr = 1'b1; ex.wval = a & b; set_f = 1'b1;
                end
                ACT_EOR:     begin ex.wr = 1'b1; ex.wval = a ^ b; end
                ACT_ORR:     begin ex.wr = 1'b1; ex.wval = a | b; end
                ACT_ADD_REG: begin ex.wr = 1'b1; ex.wval = a + b; end
                ACT_ADD_IMM: begin ex.wr = 1'b1; ex.wval = a + 64'(r_b.imm12); end
                ACT_MUL:     begin ex.wr = 1'b1; ex.is_mul = 1'b1; end
                ACT_MOVZ: begin
                    ex.wr = 1'b1; ex.wval = 64'(r_b.imm16); set_f = 1'b1;
                end
                ACT_SHIFT: begin
                    ex.wr = 1'b1;
                    if (r_b.imm12[5:0] != 6'd63) begin
                        ex.wval = a << (6'd63 - r_b.imm12[5:0]);
                    end else begin
                        ex.wval = a >> r_b.imm12[11:6];
                    end
                end
                ACT_B:  ex.next_pc = r_pc + off26;
                ACT_BR: ex.next_pc = a;
                ACT_BCOND: begin
                    case (r_b.cond_code)
                        COND_EQ: take = r_z;
                        COND_NE: take = !r_z;
                        COND_GT: take = !r_n && !r_z;
                        COND_LT: take = r_n;
                        COND_GE: take = !r_n;
                        COND_LE: take = r_n || r_z;
                        default: take = 1'b0;
                    endcase
                    if (take) ex.next_pc = r_pc + off19;
                end
                ACT_CBZ:  if (t == 64'd0) ex.next_pc = r_pc + off19;
                ACT_CBNZ: if (t != 64'd0) ex.next_pc = r_pc + off19;
                ACT_LDUR, ACT_LDURH, ACT_LDURB: begin
                    ex.wr      = 1'b1;
                    ex.wreg    = r_b.data_reg;
                    ex.is_load = 1'b1;
                    ex.msize   = (t_action'(r_b.action) == ACT_LDURB) ? MSZ_B :
                                 (t_action'(r_b.action) == ACT_LDURH) ? MSZ_H : MSZ_D;
                end
                ACT_STUR, ACT_STURH, ACT_STURB: begin
                    mop.we   = r_b_valid;
                    mop.size = (t_action'(r_b.action) == ACT_STURB) ? MSZ_B :
                               (t_action'(r_b.action) == ACT_STURH) ? MSZ_H : MSZ_D;
                end
                ACT_HLT: begin
                    ex.halt    = 1'b1;
                    ex.next_pc = r_pc;
                end
                default: ;
            endcase
        end
        fv = ex.wval;
        if (set_f) begin
            ex.fn = fv[63];
            ex.fz = (fv == 64'd0);
        end
        if (!ex.wr || ex.wreg == ZERO_REG) begin
            ex.wr      = 1'b0;
            ex.wreg    = '0;
            ex.wval    = '0;
            ex.is_mul  = 1'b0;
            ex.is_load = 1'b0;
        end
    end

    // write-back stage
    always_comb begin
        case (r_c.msize)
            MSZ_B:   ld = {56'd0, mem_q[7:0]};
            MSZ_H:   ld = {48'd0, mem_q[15:0]};
            default: ld = mem_q;
        endcase
        if (r_c.is_mul) begin
            cval = r_p_ll + {r_p_lh + r_p_hl, 32'd0};
        end else if (r_c.is_load) begin
            cval = ld;
        end else begin
            cval = r_c.wval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= '0;
            r_n         <= 1'b0;
            r_z         <= 1'b0;
            r_halt      <= 1'b0;
        end else begin
            r_b_valid <= accept;
            r_c_valid <= r_b_valid || (r_c_valid && !c_done);
            if (c_done) begin
                r_out_valid <= 1'b1;
                r_pc        <= r_c.next_pc;
                r_n         <= r_c.fn;
                r_z         <= r_c.fz;
                r_halt      <= r_c.halt;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b.action    <= i_instr.action;
            r_b.dest_reg  <= i_instr.dest_reg;
            r_b.data_reg  <= i_instr.data_reg;
            r_b.cond_code <= i_instr.cond_code;
            r_b.imm12     <= i_instr.imm12;
            r_b.imm16     <= i_instr.imm16;
            r_b.off26     <= i_instr.branch_offset26;
            r_b.off19     <= i_instr.branch_offset19;
            r_b.off9      <= i_instr.mem_offset9;
        end
        if (r_b_valid) begin
            r_c    <= ex;
            r_p_ll <= a[31:0] * b[31:0];
            r_p_lh <= 32'(a[31:0] * b[63:32]);
            r_p_hl <= 32'(a[63:32] * b[31:0]);
        end
        if (c_done) begin
            o_result.next_pc       <= r_c.next_pc;
            o_result.reg_write     <= r_c.wr;
            o_result.written_reg   <= r_c.wreg;
            o_result.written_value <= cval;
            o_result.flag_neg      <= r_c.fn;
            o_result.flag_zero     <= r_c.fz;
            o_result.halted        <= r_c.halt;
        end
    end

    assign o_result.valid = r_out_valid;
endmodule

@@ rtl/core/xu_ram.sv @@
module xu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/xu_regfile.sv @@
module xu_regfile
    import xu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_re,
    input  logic [4:0]  i_raddr_a,
    input  logic [4:0]  i_raddr_b,
    input  logic [4:0]  i_raddr_t,
    input  logic        i_we,
    input  logic [4:0]  i_waddr,
    input  logic [63:0] i_wdata,
    output logic [63:0] o_a,
    output logic [63:0] o_b,
    output logic [63:0] o_t
);
    logic [63:0] q_a, q_b, q_t;
    logic [4:0]  r_ra, r_rb, r_rt;
    logic [31:0] r_valid;
    logic        r_fwd_vld;
    logic [4:0]  r_fwd_reg;
    logic [63:0] r_fwd_val;

    // three copies give three read ports, all written together
    xu_ram #(.WIDTH(64), .DEPTH(32)) u_copy_a (
        .i_clk, .i_we, .i_waddr, .i_wdata, .i_re, .i_raddr(i_raddr_a), .o_rdata(q_a)
    );
    xu_ram #(.WIDTH(64), .DEPTH(32)) u_copy_b (
        .i_clk, .i_we, .i_waddr, .i_wdata, .i_re, .i_raddr(i_raddr_b), .o_rdata(q_b)
    );
    xu_ram #(.WIDTH(64), .DEPTH(32)) u_copy_t (
        .i_clk, .i_we, .i_waddr, .i_wdata, .i_re, .i_raddr(i_raddr_t), .o_rdata(q_t)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_fwd_vld <= 1'b0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
            r_fwd_vld        <= 1'b1;
        end
        if (i_we) begin
            r_fwd_reg <= i_waddr;
            r_fwd_val <= i_wdata;
        end
        if (i_re) begin
            r_ra <= i_raddr_a;
            r_rb <= i_raddr_b;
            r_rt <= i_raddr_t;
        end
    end

    // latest write wins over a read that raced it
    function automatic logic [63:0] pick(logic [4:0] ra, logic [63:0] q, logic [31:0] vld,
                                         logic fv, logic [4:0] fr, logic [63:0] fval);
        if (ra == ZERO_REG)     return 64'd0;
        if (fv && fr == ra)     return fval;
        if (vld[ra])            return q;
        return 64'd0;
    endfunction

    assign o_a = pick(r_ra, q_a, r_valid, r_fwd_vld, r_fwd_reg, r_fwd_val);
    assign o_b = pick(r_rb, q_b, r_valid, r_fwd_vld, r_fwd_reg, r_fwd_val);
    assign o_t = pick(r_rt, q_t, r_valid, r_fwd_vld, r_fwd_reg, r_fwd_val);
endmodule

@@ rtl/core/xu_dmem.sv @@
module xu_dmem
    import xu_pkg::*;
#(
    parameter int DMEM_BYTES = 4096,
    localparam int AW = $clog2(DMEM_BYTES)
) (
    input  logic          i_clk,
    input  t_mem_op       i_op,
    input  logic [AW-1:0] i_addr,
    input  logic [63:0]   i_wdata,
    output logic [63:0]   o_rdata
);
    localparam int ROWS = DMEM_BYTES / 8;
    localparam int RW   = AW - 3;

    logic [2:0]    a0;
    logic [RW-1:0] base;
    logic [3:0]    nbytes;
    logic [2:0]    r_a0;
    logic [7:0]    lane_q [8];

    assign a0     = i_addr[2:0];
    assign base   = i_addr[AW-1:3];
    assign nbytes = msize_bytes(i_op.size);

    for (genvar l = 0; l < 8; l++) begin : g_lane
        logic [2:0]    off;
        logic [RW-1:0] row;
        logic          we;
        logic [63:0]   sh;

        assign off = 3'(l) - a0;
        assign row = base + RW'(3'(l) < a0);
        assign we  = i_op.we && ({1'b0, off} < nbytes);
        assign sh  = i_wdata >> {off, 3'b000};

        xu_ram #(.WIDTH(8), .DEPTH(ROWS)) u_lane (
            .i_clk,
            .i_we(we),
            .i_waddr(row),
            .i_wdata(sh[7:0]),
            .i_re(i_op.re),
            .i_raddr(row),
            .o_rdata(lane_q[l])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_op.re) begin
            r_a0 <= a0;
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            o_rdata[8*i +: 8] = lane_q[3'(r_a0 + 3'(i))];
        end
    end
endmodule

@@ sim/armv8_subset_execute_unit_test.sv @@
module armv8_subset_execute_unit_test;
    import xu_pkg::*;

    localparam int MEM_BYTES = 4096;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [4:0]         action;
        logic [4:0]         dest_reg;
        logic [4:0]         src_reg_a;
        logic [4:0]         src_reg_b;
        logic [4:0]         data_reg;
        logic [3:0]         cond_code;
        logic [11:0]        imm12;
        logic [15:0]        imm16;
        logic signed [25:0] off26;
        logic signed [18:0] off19;
        logic signed [8:0]  off9;
    } t_insn;

    typedef struct {
        logic [63:0] next_pc;
        logic        reg_write;
        logic [4:0]  written_reg;
        logic [63:0] written_value;
        logic        flag_neg;
        logic        flag_zero;
        logic        halted;
    } t_retire;

    // architectural shadow of the unit plus the queue of pending retirements
    class exec_scoreboard;
        logic [63:0] regs [32];
        logic [63:0] pc;
        logic        fn, fz, halt;
        logic [7:0]  mem [MEM_BYTES];
        bit          mem_valid [MEM_BYTES];
        t_retire     pending [$];
        int          mismatches;

        function void clear();
            foreach (regs[i]) regs[i] = '0;
            foreach (mem_valid[i]) mem_valid[i] = 0;
            pc = '0; fn = 0; fz = 0; halt = 0;
            pending.delete();
            mismatches = 0;
        endfunction

        function logic [63:0] rd(logic [4:0] r);
            return (r == ZERO_REG) ? 64'd0 : regs[r];
        endfunction

        function void set_nz(logic [63:0] v);
            fn = v[63];
            fz = (v == 64'd0);
        endfunction

        function bit bytes_written(logic [63:0] addr, int n);
            for (int i = 0; i < n; i++)
                if (!mem_valid[(addr + i) % MEM_BYTES]) return 0;
            return 1;
        endfunction

        function void note_instr(t_insn t);
            logic [63:0] a, b, addr, nxt, wv;
            logic [4:0]  wr_r;
            bit          wr, take;
            int          n;
            t_retire     r;
            a = rd(t.src_reg_a);
            b = rd(t.src_reg_b);
            addr = a + 64'(t.off9);
            nxt = pc + 4;
            wr = 0; wr_r = t.dest_reg; wv = '0; n = 0;
            if (halt) begin
                nxt = pc;
            end else begin
                case (t_action'(t.action))
                    ACT_ADDS_REG: begin wr = 1; wv = a + b; set_nz(wv); end
                    ACT_ADDS_IMM: begin wr = 1; wv = a + t.imm12; set_nz(wv); end
                    ACT_SUBS_REG: begin wr = 1; wv = a - b; set_nz(wv); end
                    ACT_SUBS_IMM: begin wr = 1; wv = a - t.imm12; set_nz(wv); end
                    ACT_CMP_IMM:  set_nz(a - t.imm12);
                    ACT_ANDS:     begin wr = 1; wv = a & b; set_nz(wv); end
                    ACT_EOR:      begin wr = 1; wv = a ^ b; end
                    ACT_ORR:      begin wr = 1; wv = a | b; end
                    ACT_ADD_REG:  begin wr = 1; wv = a + b; end
                    ACT_ADD_IMM:  begin wr = 1; wv = a + t.imm12; end
                    ACT_MUL:      begin wr = 1; wv = a * b; end
                    ACT_MOVZ:     begin wr = 1; wv = t.imm16; set_nz(wv); end
                    ACT_SHIFT: begin
                        wr = 1;
                        if (t.imm12[5:0] != 6'd63) wv = a << (6'd63 - t.imm12[5:0]);
                        else wv = a >> t.imm12[11:6];
                    end
                    ACT_B:  nxt = pc + (64'(t.off26) << 2);
                    ACT_BR: nxt = a;
                    ACT_BCOND: begin
                        case (t.cond_code)
                            COND_EQ: take = fz;
                            COND_NE: take = !fz;
                            COND_GT: take = !fn && !fz;
                            COND_LT: take = fn;
                            COND_GE: take = !fn;
                            COND_LE: take = fn || fz;
                            default: take = 0;
                        endcase
                        if (take) nxt = pc + (64'(t.off19) << 2);
                    end
                    ACT_CBZ:  if (rd(t.data_reg) == 0) nxt = pc + (64'(t.off19) << 2);
                    ACT_CBNZ: if (rd(t.data_reg) != 0) nxt = pc + (64'(t.off19) << 2);
                    ACT_LDUR, ACT_LDURH, ACT_LDURB: begin
                        n = (t.action == ACT_LDUR) ? 8 : (t.action == ACT_LDURH) ? 2 : 1;
                        wr = 1; wr_r = t.data_reg;
                        for (int i = 0; i < n; i++)
                            wv[8*i +: 8] = mem[(addr + i) % MEM_BYTES];
                    end
                    ACT_STUR, ACT_STURH, ACT_STURB: begin
                        n = (t.action == ACT_STUR) ? 8 : (t.action == ACT_STURH) ? 2 : 1;
                        for (int i = 0; i < n; i++) begin
                            mem[(addr + i) % MEM_BYTES] = 8'(rd(t.data_reg) >> (8*i));
                            mem_valid[(addr + i) % MEM_BYTES] = 1;
                        end
                    end
                    ACT_HLT: begin halt = 1; nxt = pc; end
                    default: ;
                endcase
            end
            if (wr && wr_r != ZERO_REG) regs[wr_r] = wv;
            else begin wr = 0; wr_r = '0; wv = '0; end
            pc = nxt;
            r.next_pc = pc; r.reg_write = wr; r.written_reg = wr_r;
            r.written_value = wv; r.flag_neg = fn; r.flag_zero = fz; r.halted = halt;
            pending.push_back(r);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %h expected %h", what, got, want);
            mismatches++;
        endtask

        task check_retire(t_retire g);
            t_retire e;
            if (pending.size() == 0) begin
                report("unexpected result, next_pc", g.next_pc, 64'bx);
                return;
            end
            e = pending.pop_front();
            if (g.next_pc !== e.next_pc) report("next_pc", g.next_pc, e.next_pc);
            if (g.reg_write !== e.reg_write) report("reg_write", g.reg_write, e.reg_write);
            if (g.written_reg !== e.written_reg)
                report("written_reg", g.written_reg, e.written_reg);
            if (g.written_value !== e.written_value)
                report("written_value", g.written_value, e.written_value);
            if (g.flag_neg !== e.flag_neg) report("flag_neg", g.flag_neg, e.flag_neg);
            if (g.flag_zero !== e.flag_zero) report("flag_zero", g.flag_zero, e.flag_zero);
            if (g.halted !== e.halted) report("halted", g.halted, e.halted);
        endtask
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    xu_instr_if  instr_ch ();
    xu_result_if result_ch ();

    armv8_subset_execute_unit #(.DMEM_BYTES(MEM_BYTES)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_instr (instr_ch.sink),
        .o_result(result_ch.source)
    );

    always #5 i_clk = ~i_clk;

    exec_scoreboard sb = new();
    int  cycles = 0;
    bit  calm = 0;
    int  sent = 0;
    int  retired = 0;
    int  sink_hold = 0;
    t_insn plan [$];

    initial begin
        instr_ch.valid = 0;
        instr_ch.action = '0; instr_ch.dest_reg = '0; instr_ch.src_reg_a = '0;
        instr_ch.src_reg_b = '0; instr_ch.data_reg = '0; instr_ch.cond_code = '0;
        instr_ch.imm12 = '0; instr_ch.imm16 = '0; instr_ch.branch_offset26 = '0;
        instr_ch.branch_offset19 = '0; instr_ch.mem_offset9 = '0;
        result_ch.ready = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stall bursts, none once the run goes calm
    always @(posedge i_clk) begin
        t_retire g;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            g.next_pc = result_ch.next_pc; g.reg_write = result_ch.reg_write;
            g.written_reg = result_ch.written_reg;
            g.written_value = result_ch.written_value;
            g.flag_neg = result_ch.flag_neg; g.flag_zero = result_ch.flag_zero;
            g.halted = result_ch.halted;
            sb.check_retire(g);
            retired++;
        end
        if (!i_rst_n || calm) begin
            result_ch.ready <= i_rst_n;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            result_ch.ready <= 0;
        end else if ($urandom_range(0, 5) == 0) begin
            sink_hold <= $urandom_range(0, 3);
            result_ch.ready <= 0;
        end else begin
            result_ch.ready <= 1;
        end
    end

    task automatic send(t_insn t);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            instr_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        instr_ch.valid <= 1;
        instr_ch.action <= t.action; instr_ch.dest_reg <= t.dest_reg;
        instr_ch.src_reg_a <= t.src_reg_a; instr_ch.src_reg_b <= t.src_reg_b;
        instr_ch.data_reg <= t.data_reg; instr_ch.cond_code <= t.cond_code;
        instr_ch.imm12 <= t.imm12; instr_ch.imm16 <= t.imm16;
        instr_ch.branch_offset26 <= t.off26; instr_ch.branch_offset19 <= t.off19;
        instr_ch.mem_offset9 <= t.off9;
        do @(posedge i_clk); while (!instr_ch.ready);
        sb.note_instr(t);
        sent++;
    endtask

    function automatic t_insn rand_fields();
        t_insn t;
        t.action = 5'($urandom_range(0, 31)); t.dest_reg = 5'($urandom);
        t.src_reg_a = 5'($urandom);
        t.src_reg_b = 5'($urandom); t.data_reg = 5'($urandom); t.cond_code = 4'($urandom);
        t.imm12 = 12'($urandom); t.imm16 = 16'($urandom); t.off26 = 26'($urandom);
        t.off19 = 19'($urandom); t.off9 = 9'($urandom);
        return t;
    endfunction

    function automatic t_insn op(t_action a, logic [4:0] d, logic [4:0] s1, logic [4:0] s2);
        t_insn t;
        t = rand_fields();
        t.action = a; t.dest_reg = d; t.src_reg_a = s1; t.src_reg_b = s2;
        return t;
    endfunction

    // loads keep to written bytes; a load of unwritten bytes becomes a store
    function automatic t_insn fix_mem(t_insn t);
        logic [63:0] addr;
        int n;
        if (t.action inside {ACT_LDUR, ACT_LDURH, ACT_LDURB}) begin
            n = (t.action == ACT_LDUR) ? 8 : (t.action == ACT_LDURH) ? 2 : 1;
            addr = sb.rd(t.src_reg_a) + 64'(t.off9);
            if (!sb.bytes_written(addr, n)) t.action = t.action + 5'd3;
        end
        return t;
    endfunction

    initial begin
        t_insn t;
        int k;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        sb.clear();
        @(posedge i_clk);

        // directed: extremes, every arithmetic and branch operation, some loads and stores, flags, zero register
        t = op(ACT_MOVZ, 1, 0, 0); t.imm16 = 16'hFFFF; plan.push_back(t);
        t = op(ACT_MOVZ, 2, 0, 0); t.imm16 = 0; plan.push_back(t);
        t = op(ACT_SUBS_IMM, 3, 31, 0); t.imm12 = 12'hFFF; plan.push_back(t);
        t = op(ACT_SUBS_REG, 31, 1, 1); plan.push_back(t);
        t = op(ACT_ADDS_REG, 4, 3, 1); plan.push_back(t);
        t = op(ACT_ADDS_IMM, 5, 3, 0); t.imm12 = 12'hFFF; plan.push_back(t);
        t = op(ACT_CMP_IMM, 0, 1, 0); t.imm12 = 12'hFFF; plan.push_back(t);
        t = op(ACT_ANDS, 6, 3, 1); plan.push_back(t);
        t = op(ACT_EOR, 7, 3, 1); plan.push_back(t);
        t = op(ACT_ORR, 8, 3, 31); plan.push_back(t);
        t = op(ACT_ADD_REG, 9, 3, 3); plan.push_back(t);
        t = op(ACT_ADD_IMM, 10, 31, 0); t.imm12 = 0; plan.push_back(t);
        t = op(ACT_MUL, 11, 3, 3); plan.push_back(t);
        t = op(ACT_SHIFT, 12, 1, 0); t.imm12 = 12'd0; plan.push_back(t);
        t = op(ACT_SHIFT, 13, 3, 0); t.imm12 = {6'd63, 6'd63}; plan.push_back(t);
        t = op(ACT_STUR, 0, 31, 0); t.data_reg = 3; t.off9 = -256; plan.push_back(t);
        t = op(ACT_LDUR, 0, 31, 0); t.data_reg = 14; t.off9 = -256; plan.push_back(t);
        t = op(ACT_STURH, 0, 31, 0); t.data_reg = 1; t.off9 = 255; plan.push_back(t);
        t = op(ACT_LDURB, 0, 31, 0); t.data_reg = 15; t.off9 = 255; plan.push_back(t);
        t = op(ACT_B, 0, 0, 0); t.off26 = -26'sd33554432; plan.push_back(t);
        t = op(ACT_BCOND, 0, 0, 0); t.cond_code = COND_LT; t.off19 = 19'sd262143;
        plan.push_back(t);
        t = op(ACT_BCOND, 0, 0, 0); t.cond_code = 4'd7; plan.push_back(t);
        t = op(ACT_CBZ, 0, 0, 0); t.data_reg = 31; t.off19 = -19'sd262144; plan.push_back(t);
        t = op(ACT_CBNZ, 0, 0, 0); t.data_reg = 3; plan.push_back(t);
        t = op(ACT_BR, 0, 3, 0); plan.push_back(t);
        foreach (plan[i]) send(fix_mem(plan[i]));
        t = rand_fields(); t.action = 5'd27; send(t);

        // random: any action code (no halt but the last), registers mostly 0 to 7, memory base often the zero register
        for (k = 0; k < 640; k++) begin
            if (k >= 560) calm = 1;
            t = rand_fields();
            if ($urandom_range(0, 3) != 0) begin
                t.dest_reg = 5'($urandom_range(0, 7)); t.src_reg_a = 5'($urandom_range(0, 7));
                t.src_reg_b = 5'($urandom_range(0, 7)); t.data_reg = 5'($urandom_range(0, 7));
                if ($urandom_range(0, 1)) t.src_reg_a = 31;
                if ($urandom_range(0, 9) == 0) t.dest_reg = 31;
            end
            if (t.action == ACT_HLT && k != 639) t.action = ACT_MOVZ;
            if (k == 639) t.action = ACT_HLT;
            send(fix_mem(t));
        end
        // halted unit ignores everything
        repeat (6) send(fix_mem(rand_fields()));
        instr_ch.valid <= 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("ran %0d instructions, %0d results checked across all operations", sent,
                 retired);
        $display("halt reached and post-halt items ignored");
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/xu_pkg.sv
rtl/core/xu_if.sv
rtl/core/xu_ram.sv
rtl/core/xu_regfile.sv
rtl/core/xu_dmem.sv
rtl/core/armv8_subset_execute_unit.sv
sim/armv8_subset_execute_unit_test.sv
